### rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the serial frame parser: frame phases,
// status codes and the result record passed to the output buffer.
// ----------------------------------------------------------------------------
package sfp_pkg;

   // frame layout constants
   localparam logic [7:0] START_BYTE  = 8'hAA;
   localparam int         MAX_PAYLOAD = 16;
   localparam int         STORE_DEPTH = 16;
   localparam int         INDEX_W     = $clog2(STORE_DEPTH);
   localparam int         LEN_W       = 5;
   localparam int         HALF_BYTES  = 8;

   // parser phase
   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   // reported status per byte
   typedef enum logic [2:0] {
      ST_BUSY    = 3'd0,
      ST_OK      = 3'd1,
      ST_SUM_ERR = 3'd2,
      ST_TIMEOUT = 3'd3,
      ST_LEN_ERR = 3'd4
   } status_type;

   // one result record
   typedef struct packed {
      status_type        status;
      logic [7:0]        command;
      logic [LEN_W-1:0]  frame_len;
      logic [63:0]       payload_low;
      logic [63:0]       payload_high;
   } rsp_type;

endpackage

### rtl/sfp_core.sv
// ----------------------------------------------------------------------------
// sfp_core
// Frame state machine: hunts for the start byte, collects command, length,
// payload and checksum, checks the inter-byte gap, and forms one result for
// every transferred byte.
// ----------------------------------------------------------------------------
module sfp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic [31:0]         arrival_time,
   output sfp_pkg::rsp_type    result
);

   sfp_pkg::phase_type                   phase_ff, phase_in;
   logic [7:0]                           command_ff, command_in;
   logic [sfp_pkg::LEN_W-1:0]            length_ff, length_in;
   logic [sfp_pkg::LEN_W-1:0]            index_ff, index_in;
   logic [7:0]                           xor_ff, xor_in;
   logic [31:0]                          last_time_ff, last_time_in;
   logic [31:0]                          gap_timeout_ff;
   logic [7:0]                           store_ff [sfp_pkg::STORE_DEPTH];
   logic [7:0]                           store_in [sfp_pkg::STORE_DEPTH];
   logic [sfp_pkg::LEN_W-1:0]            index_inc;
   logic [31:0]                          gap;
   logic                                 timed_out;
   logic                                 restart;
   logic                                 store_wr;
   logic [8*sfp_pkg::STORE_DEPTH-1:0]    packed_payload;

   // gap since the last frame byte, modulo 2^32
   assign gap       = arrival_time - last_time_ff;
   assign timed_out = (gap_timeout_ff != 32'd0) && (phase_ff != sfp_pkg::PH_WAIT)
                      && (gap > gap_timeout_ff);
   assign index_inc = index_ff + 1'b1;

   // payload packing, bytes at or past the length read zero
   always_comb begin
      for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
         if (sfp_pkg::LEN_W'(k) < length_ff) begin
            packed_payload[8*k +: 8] = store_ff[k];
         end else begin
            packed_payload[8*k +: 8] = 8'd0;
         end
      end
   end

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      index_in     = index_ff;
      xor_in       = xor_ff;
      last_time_in = last_time_ff;
      restart      = 1'b0;
      store_wr     = 1'b0;
      result       = '0;
      result.status = sfp_pkg::ST_BUSY;

      if (timed_out) begin
         restart       = 1'b1;
         result.status = sfp_pkg::ST_TIMEOUT;
      end else begin
         case (phase_ff)
            sfp_pkg::PH_WAIT: begin
            end
            sfp_pkg::PH_CMD: begin
               command_in   = rx_byte;
               xor_in       = rx_byte;
               phase_in     = sfp_pkg::PH_LEN;
               last_time_in = arrival_time;
            end
            sfp_pkg::PH_LEN: begin
               xor_in   = xor_ff ^ rx_byte;
               index_in = '0;
               if (rx_byte > 8'(sfp_pkg::MAX_PAYLOAD)) begin
                  restart       = 1'b1;
                  result.status = sfp_pkg::ST_LEN_ERR;
               end else begin
                  length_in    = rx_byte[sfp_pkg::LEN_W-1:0];
                  phase_in     = (rx_byte == 8'd0) ? sfp_pkg::PH_SUM : sfp_pkg::PH_DATA;
                  last_time_in = arrival_time;
               end
            end
            sfp_pkg::PH_DATA: begin
               store_wr     = 1'b1;
               xor_in       = xor_ff ^ rx_byte;
               index_in     = index_inc;
               if (index_inc >= length_ff) begin
                  phase_in = sfp_pkg::PH_SUM;
               end
               last_time_in = arrival_time;
            end
            sfp_pkg::PH_SUM: begin
               last_time_in = arrival_time;
               restart      = 1'b1;
               if (rx_byte == xor_ff) begin
                  result.status       = sfp_pkg::ST_OK;
                  result.command      = command_ff;
                  result.frame_len    = length_ff;
                  result.payload_low  = packed_payload[63:0];
                  result.payload_high = packed_payload[127:64];
               end else begin
                  result.status = sfp_pkg::ST_SUM_ERR;
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase
      end

      // parser restart clears the frame context
      if (restart) begin
         phase_in   = sfp_pkg::PH_WAIT;
         command_in = '0;
         length_in  = '0;
         index_in   = '0;
         xor_in     = '0;
      end

      // a waiting parser (or one just timed out) treats the byte as a start candidate
      if ((timed_out || phase_ff == sfp_pkg::PH_WAIT) && rx_byte == sfp_pkg::START_BYTE) begin
         phase_in     = sfp_pkg::PH_CMD;
         last_time_in = arrival_time;
      end
   end

   // payload store next value
   always_comb begin
      for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
         if (restart) begin
            store_in[k] = 8'd0;
         end else if (store_wr && index_ff[sfp_pkg::INDEX_W-1:0] == sfp_pkg::INDEX_W'(k)) begin
            store_in[k] = rx_byte;
         end else begin
            store_in[k] = store_ff[k];
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfp_pkg::PH_WAIT;
         command_ff   <= '0;
         length_ff    <= '0;
         index_ff     <= '0;
         xor_ff       <= '0;
         last_time_ff <= '0;
         for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
            store_ff[k] <= 8'd0;
         end
      end else if (accept) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         index_ff     <= index_in;
         xor_ff       <= xor_in;
         last_time_ff <= last_time_in;
         store_ff     <= store_in;
      end
   end

   // gap timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_timeout_ff <= '0;
      end else if (csr_wr_en) begin
         gap_timeout_ff <= csr_wr_data;
      end
   end

endmodule

### rtl/sfp_out_buf.sv
// ----------------------------------------------------------------------------
// sfp_out_buf
// Two-entry output buffer: a result register plus a skid register, so the
// upstream stall comes straight from a flop and results keep flowing.
// ----------------------------------------------------------------------------
module sfp_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfp_pkg::rsp_type    push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output sfp_pkg::rsp_type    out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   sfp_pkg::rsp_type  main_ff, main_in;
   sfp_pkg::rsp_type  skid_ff, skid_in;
   logic              take;

   assign take      = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // buffer control
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### rtl/serial_frame_parser.sv
// ----------------------------------------------------------------------------
// serial_frame_parser
// Byte-serial frame receiver with start byte, command, length, payload and
// XOR checksum, plus an inter-byte gap timeout.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte and its millisecond timestamp per transfer
//   (req_valid high, req_stall low). Every byte gives exactly one result on
//   rsp_*: status 0 while idle or mid-frame, otherwise frame ok,
//   checksum error, timeout or length error. On frame ok, command, length and
//   the payload (packed little-end first, zero past the length) are shown.
//   csr_wr_en/csr_wr_data set the gap timeout in ms (0 disables it); write
//   it while no transfer is outstanding.
//   A result is registered in the output buffer when its byte is transferred.
//   Throughput is one byte per cycle while rsp_stall stays low, set by the
//   parser update and the result register.
//   A two-entry output buffer absorbs a stall: req_stall rises only once two
//   results are waiting, and comes from a flop.
//   Synchronous reset clears the parser, the gap timeout and the buffer.
// ----------------------------------------------------------------------------
module serial_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic [31:0]  req_arrival_time,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_status,
   output logic [7:0]   rsp_command,
   output logic [4:0]   rsp_frame_len,
   output logic [63:0]  rsp_payload_low,
   output logic [63:0]  rsp_payload_high
);

   logic              accept;
   logic              buf_full;
   sfp_pkg::rsp_type  core_result;
   sfp_pkg::rsp_type  out_result;

   // input transfer
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // parser
   sfp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .arrival_time (req_arrival_time),
      .result       (core_result)
   );

   // result buffer
   sfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_result)
   );

   // result fields
   assign rsp_status       = out_result.status;
   assign rsp_command      = out_result.command;
   assign rsp_frame_len    = out_result.frame_len;
   assign rsp_payload_low  = out_result.payload_low;
   assign rsp_payload_high = out_result.payload_high;

endmodule
